// ----- design/sh24_pkg.sv -----
`default_nettype none

package sh24_pkg;

  localparam logic [63:0] INIT_C0 = 64'h736f6d6570736575;
  localparam logic [63:0] INIT_C1 = 64'h646f72616e646f6d;
  localparam logic [63:0] INIT_C2 = 64'h6c7967656e657261;
  localparam logic [63:0] INIT_C3 = 64'h7465646279746573;

  localparam logic [63:0] FIN_MARK = 64'h00000000000000ff;

  localparam logic [3:0] FULL_BYTES = 4'd8;

  // Register select, taken from paddr[3]
  localparam logic REG_KEY_LOW  = 1'b0;
  localparam logic REG_KEY_HIGH = 1'b1;

  typedef struct packed {
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] v2;
    logic [63:0] v3;
  } lanes_t;

  typedef struct packed {
    lanes_t      lanes;
    logic [63:0] block;
  } fin_item_t;

  function automatic lanes_t sip_round(input lanes_t s);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
    lanes_t      r;
    a = s.v0;
    b = s.v1;
    c = s.v2;
    d = s.v3;
    a = a + b;
    b = {b[50:0], b[63:51]};
    b = b ^ a;
    a = {a[31:0], a[63:32]};
    c = c + d;
    d = {d[47:0], d[63:48]};
    d = d ^ c;
    a = a + d;
    d = {d[42:0], d[63:43]};
    d = d ^ a;
    c = c + b;
    b = {b[46:0], b[63:47]};
    b = b ^ c;
    c = {c[31:0], c[63:32]};
    r.v0 = a;
    r.v1 = b;
    r.v2 = c;
    r.v3 = d;
    return r;
  endfunction

  // Mix one 64-bit block into the lanes with two rounds
  function automatic lanes_t absorb(input lanes_t s, input logic [63:0] m);
    lanes_t t;
    t    = s;
    t.v3 = t.v3 ^ m;
    t    = sip_round(t);
    t    = sip_round(t);
    t.v0 = t.v0 ^ m;
    return t;
  endfunction

endpackage

`default_nettype wire

// ----- design/sh24_absorb.sv -----
`default_nettype none

module sh24_absorb (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [63:0]          key_low,
  input  wire logic [63:0]          key_high,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [63:0]          msg_word,
  input  wire logic [3:0]           byte_count,
  input  wire logic                 last_word,
  output logic                      fin_valid,
  input  wire logic                 fin_stall,
  output sh24_pkg::fin_item_t       fin_item
);

  sh24_pkg::lanes_t lanes;
  logic [7:0]       length;
  logic             at_start;

  sh24_pkg::lanes_t start_lanes;
  sh24_pkg::lanes_t word_lanes;
  sh24_pkg::lanes_t tail_lanes;
  logic [7:0]       base_length;
  logic [7:0]       length_next;
  logic [3:0]       count;
  logic             full;
  logic [63:0]      byte_mask;
  logic [63:0]      block;
  logic             accept;

  assign in_stall = fin_valid && fin_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (at_start) begin
      start_lanes.v0 = sh24_pkg::INIT_C0 ^ key_low;
      start_lanes.v1 = sh24_pkg::INIT_C1 ^ key_high;
      start_lanes.v2 = sh24_pkg::INIT_C2 ^ key_low;
      start_lanes.v3 = sh24_pkg::INIT_C3 ^ key_high;
      base_length    = 8'd0;
    end else begin
      start_lanes = lanes;
      base_length = length;
    end
  end

  // A short word not marked last still counts as eight bytes
  assign full  = !last_word || (byte_count >= sh24_pkg::FULL_BYTES);
  assign count = full ? sh24_pkg::FULL_BYTES : byte_count;

  assign word_lanes  = sh24_pkg::absorb(start_lanes, msg_word);
  assign tail_lanes  = full ? word_lanes : start_lanes;
  assign length_next = base_length + {4'd0, count};

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      byte_mask[i*8 +: 8] = (4'(i) < count) ? 8'hff : 8'h00;
    end
  end

  assign block = {length_next, 56'd0} | (full ? 64'd0 : (msg_word & byte_mask));

  always_ff @(posedge clk) begin
    if (rst) begin
      at_start  <= 1'b1;
      length    <= 8'd0;
      fin_valid <= 1'b0;
    end else begin
      if (accept && !last_word) begin
        at_start <= 1'b0;
        length   <= length_next;
      end else if (accept) begin
        at_start <= 1'b1;
      end
      if (accept && last_word) begin
        fin_valid <= 1'b1;
      end else if (!fin_stall) begin
        fin_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !last_word) begin
      lanes <= word_lanes;
    end
    if (accept && last_word) begin
      fin_item.lanes <= tail_lanes;
      fin_item.block <= block;
    end
  end

endmodule

`default_nettype wire

// ----- design/sh24_final.sv -----
`default_nettype none

module sh24_final (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 fin_valid,
  output logic                      fin_stall,
  input  wire sh24_pkg::fin_item_t  fin_item,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [63:0]               hash_value
);

  sh24_pkg::lanes_t mix_lanes;
  sh24_pkg::lanes_t rnd_lanes;
  logic             mix_valid;
  logic             rnd_valid;

  sh24_pkg::lanes_t blk_lanes;
  sh24_pkg::lanes_t rnd_next;
  sh24_pkg::lanes_t last_lanes;

  logic out_hold;
  logic rnd_hold;
  logic mix_hold;

  assign out_hold  = out_valid && out_stall;
  assign rnd_hold  = rnd_valid && out_hold;
  assign mix_hold  = mix_valid && rnd_hold;
  assign fin_stall = mix_hold;

  always_comb begin
    blk_lanes    = sh24_pkg::absorb(fin_item.lanes, fin_item.block);
    blk_lanes.v2 = blk_lanes.v2 ^ sh24_pkg::FIN_MARK;
  end

  assign rnd_next   = sh24_pkg::sip_round(sh24_pkg::sip_round(mix_lanes));
  assign last_lanes = sh24_pkg::sip_round(sh24_pkg::sip_round(rnd_lanes));

  always_ff @(posedge clk) begin
    if (rst) begin
      mix_valid <= 1'b0;
      rnd_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!mix_hold) begin
        mix_valid <= fin_valid;
      end
      if (!rnd_hold) begin
        rnd_valid <= mix_valid;
      end
      if (!out_hold) begin
        out_valid <= rnd_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!mix_hold && fin_valid) begin
      mix_lanes <= blk_lanes;
    end
    if (!rnd_hold && mix_valid) begin
      rnd_lanes <= rnd_next;
    end
    if (!out_hold && rnd_valid) begin
      hash_value <= last_lanes.v0 ^ last_lanes.v1 ^ last_lanes.v2 ^ last_lanes.v3;
    end
  end

endmodule

`default_nettype wire

// ----- design/siphash_2_4_stream_top.sv -----
// SipHash-2-4 over a stream of little-endian 64-bit words, keyed through an APB port.
// Throughput: one word per cycle while in_stall is low, every word including the last; two rounds per stage.
// The last word's hash passes the final-block register, the block-absorb stage and two
// finalisation stages, the second being the result register; out_stall can hold it there.
// Reset (rst, synchronous, active high) empties the pipeline, clears the keys to zero
// and arms the lanes for a fresh message.

`default_nettype none

module siphash_2_4_stream_top (
  input  wire logic        clk,
  input  wire logic        rst,

  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready,

  // message words
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] msg_word,
  input  wire logic [3:0]  byte_count,
  input  wire logic        last_word,

  // hash results
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      hash_value
);

  logic [63:0] key_low;
  logic [63:0] key_high;
  logic        cfg_write;

  logic                fin_valid;
  logic                fin_stall;
  sh24_pkg::fin_item_t fin_item;

  // Zero wait states; registers sit 8 bytes apart, so only paddr[3] selects
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= 64'd0;
      key_high <= 64'd0;
    end else if (cfg_write) begin
      unique case (paddr[3])
        sh24_pkg::REG_KEY_LOW:  key_low  <= pwdata;
        sh24_pkg::REG_KEY_HIGH: key_high <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      sh24_pkg::REG_KEY_LOW:  prdata = key_low;
      sh24_pkg::REG_KEY_HIGH: prdata = key_high;
      default:                prdata = 64'd0;
    endcase
  end

  // Front stage: keep the running lanes, absorb each word but a short last one with two
  // rounds, and on the last word hand the lanes and the length-tagged final block onwards.
  // The lanes load from the keys when the first word of a message arrives.
  sh24_absorb u_absorb (
    .clk        (clk),
    .rst        (rst),
    .key_low    (key_low),
    .key_high   (key_high),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .msg_word   (msg_word),
    .byte_count (byte_count),
    .last_word  (last_word),
    .fin_valid  (fin_valid),
    .fin_stall  (fin_stall),
    .fin_item   (fin_item)
  );

  // Back stages: absorb the final block, run the four finalisation rounds two
  // at a time and fold the lanes into the hash. Runs alongside the next message.
  sh24_final u_final (
    .clk        (clk),
    .rst        (rst),
    .fin_valid  (fin_valid),
    .fin_stall  (fin_stall),
    .fin_item   (fin_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hash_value (hash_value)
  );

endmodule

`default_nettype wire

// ----- design/sh24_checker.sv -----
`default_nettype none

module sh24_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        last_word,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [63:0] hash_value
);

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word present after reset");

  // A held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(hash_value))
    else $error("stalled result word changed");

  // Input back-pressure only comes from a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // Back stages empty and no stall: a last word passes the fin, mix, rnd and out registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last_word && !out_valid && !out_stall
    ##1 !out_stall ##1 !out_stall |=> ##1 out_valid)
    else $error("last word did not produce a result in time");

endmodule

bind siphash_2_4_stream_top sh24_checker u_sh24_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .last_word  (last_word),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .hash_value (hash_value)
);

`default_nettype wire

// ----- dv/hash_checker.sv -----
module hash_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic        pready,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [63:0] msg_word,
  input  wire logic [3:0]  byte_count,
  input  wire logic        last_word,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [63:0] hash_value,
  output int               errors,
  output int               pending
);

  logic [63:0]      key_lo;
  logic [63:0]      key_hi;
  sh24_pkg::lanes_t lanes;
  logic [7:0]       len_byte;
  logic             fresh;
  logic [63:0]      expected_hashes[$];
  logic [63:0]      want;

  function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
    return (x << r) | (x >> (64 - r));
  endfunction

  function automatic sh24_pkg::lanes_t one_round(input sh24_pkg::lanes_t s);
    s.v0 = s.v0 + s.v1;
    s.v1 = rotl(s.v1, 13) ^ s.v0;
    s.v0 = rotl(s.v0, 32);
    s.v2 = s.v2 + s.v3;
    s.v3 = rotl(s.v3, 16) ^ s.v2;
    s.v0 = s.v0 + s.v3;
    s.v3 = rotl(s.v3, 21) ^ s.v0;
    s.v2 = s.v2 + s.v1;
    s.v1 = rotl(s.v1, 17) ^ s.v2;
    s.v2 = rotl(s.v2, 32);
    return s;
  endfunction

  function automatic sh24_pkg::lanes_t mix_block(input sh24_pkg::lanes_t s,
                                                 input logic [63:0] m);
    s.v3 = s.v3 ^ m;
    s    = one_round(one_round(s));
    s.v0 = s.v0 ^ m;
    return s;
  endfunction

  // Advance the lane state by one accepted word; queue a hash on the last word
  function automatic void take_word(input logic [63:0] w, input logic [3:0] cnt,
                                    input logic last);
    logic [3:0]  n;
    logic [63:0] tail;
    if (fresh) begin
      lanes.v0 = sh24_pkg::INIT_C0 ^ key_lo;
      lanes.v1 = sh24_pkg::INIT_C1 ^ key_hi;
      lanes.v2 = sh24_pkg::INIT_C2 ^ key_lo;
      lanes.v3 = sh24_pkg::INIT_C3 ^ key_hi;
      len_byte = 8'd0;
      fresh    = 1'b0;
    end
    if (!last) begin
      lanes    = mix_block(lanes, w);
      len_byte = len_byte + 8'd8;
    end else begin
      n = (cnt > sh24_pkg::FULL_BYTES) ? sh24_pkg::FULL_BYTES : cnt;
      if (n == sh24_pkg::FULL_BYTES) begin
        lanes = mix_block(lanes, w);
        tail  = 64'd0;
      end else begin
        tail = w & ((64'd1 << (8 * n)) - 64'd1);
      end
      len_byte = len_byte + 8'(n);
      lanes    = mix_block(lanes, {len_byte, tail[55:0]});
      lanes.v2 = lanes.v2 ^ sh24_pkg::FIN_MARK;
      repeat (4) lanes = one_round(lanes);
      expected_hashes.push_back(lanes.v0 ^ lanes.v1 ^ lanes.v2 ^ lanes.v3);
      fresh = 1'b1;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    $display("MISMATCH at %0t: %s: got %h, want %h", $time, what, got, exp_val);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      key_lo   = '0;
      key_hi   = '0;
      lanes    = '0;
      len_byte = '0;
      fresh    = 1'b1;
      errors   = 0;
      expected_hashes.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3])
          sh24_pkg::REG_KEY_LOW:  key_lo = pwdata;
          sh24_pkg::REG_KEY_HIGH: key_hi = pwdata;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_hashes.size() == 0) begin
          report_mismatch("hash_value with no message pending", hash_value, 'x);
        end else begin
          want = expected_hashes.pop_front();
          if (hash_value !== want) report_mismatch("hash_value", hash_value, want);
        end
      end
      if (in_valid && !in_stall) take_word(msg_word, byte_count, last_word);
    end
    pending = expected_hashes.size();
  end

endmodule

// ----- dv/siphash_2_4_stream_top_test.sv -----
module siphash_2_4_stream_top_test;

  // Keys sit at byte addresses 0 and 8; bit 3 of paddr picks the half
  localparam logic [3:0] ADDR_KEY_LOW  = {sh24_pkg::REG_KEY_LOW, 3'b000};
  localparam logic [3:0] ADDR_KEY_HIGH = {sh24_pkg::REG_KEY_HIGH, 3'b000};
  // Cycles to let the pipeline run dry once nothing is owed (pipeline depth plus margin)
  localparam int LATENCY_PAD = 8;
  // Cycles with no word, hash or register access before the run is abandoned
  localparam int IDLE_LIMIT = 2000;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  logic [63:0] msg_word;
  logic [3:0]  byte_count;
  logic        last_word;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] hash_value;

  int errors;
  int pending;
  int words_sent;
  int msgs_sent;
  int key_settings;
  int hashes_seen;
  int idle_cycles;
  int stall_left;
  int stall_pick;
  int target;
  bit paused;
  bit quiet;

  siphash_2_4_stream_top dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .msg_word   (msg_word),
    .byte_count (byte_count),
    .last_word  (last_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hash_value (hash_value)
  );

  hash_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .msg_word   (msg_word),
    .byte_count (byte_count),
    .last_word  (last_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hash_value (hash_value),
    .errors     (errors),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  // Receiver back-pressure: mostly short bursts, now and then a long hold.
  // Drop it altogether while the quiet flag is up, so full-rate stretches occur.
  always @(negedge clk) begin
    if (rst || quiet) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 60) begin
        out_stall <= 1'b0;
        stall_left = $urandom_range(0, 6);
      end else if (stall_pick < 90) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(0, 2);
      end else if (stall_pick < 98) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(3, 9);
      end else begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(19, 39);
      end
    end
  end

  // Watchdog: any word, hash or register access counts as progress
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) hashes_seen++;
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("Watchdog: no progress for %0d cycles, %0d hashes outstanding",
                   IDLE_LIMIT, pending);
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  // Sender gap before a word: none while quiet, else half the time none, mostly a few cycles, rarely a long pause
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [63:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return {$urandom, $urandom};
  endfunction

  // Entered and left at a falling edge. Keep valid high across back-to-back words;
  // lower it only for a gap, so each signal sees one assignment per step.
  task automatic send_word(input logic [63:0] w, input logic [3:0] cnt, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    msg_word   <= w;
    byte_count <= cnt;
    last_word  <= last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    words_sent++;
    if (last) msgs_sent++;
  endtask

  // Park the sender and wait for every owed hash to come out
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [3:0] addr, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Rekey only once the pipeline has emptied and run dry
  task automatic set_keys(input logic [63:0] k0, input logic [63:0] k1);
    hold_until_drained();
    repeat (LATENCY_PAD) @(negedge clk);
    write_reg(ADDR_KEY_LOW, k0);
    write_reg(ADDR_KEY_HIGH, k1);
    key_settings++;
  endtask

  // Mostly short messages, some medium, a few long enough to wrap the length byte.
  // Inner words occasionally carry a stray byte count; tails sometimes overrun eight.
  task automatic send_random_message();
    int r;
    int n_full;
    logic [3:0] cnt;
    r = $urandom_range(0, 99);
    if (r < 70) n_full = $urandom_range(0, 3);
    else if (r < 95) n_full = $urandom_range(4, 12);
    else n_full = $urandom_range(28, 40);
    for (int i = 0; i < n_full; i++) begin
      cnt = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : sh24_pkg::FULL_BYTES;
      send_word(pick_word(), cnt, 1'b0);
    end
    cnt = ($urandom_range(0, 99) < 88) ? 4'($urandom_range(0, 8)) : 4'($urandom_range(9, 15));
    send_word(pick_word(), cnt, 1'b1);
  endtask

  initial begin
    clk        = 1'b0;
    rst        = 1'b1;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid   = 1'b0;
    msg_word   = '0;
    byte_count = '0;
    last_word  = 1'b0;
    out_stall  = 1'b0;
    quiet      = 1'b0;
    paused     = 1'b0;

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty message under the zero key left by reset
    send_word('0, 4'd0, 1'b1);

    // Key bytes 00..0f, then the awkward tails
    set_keys(64'h0706050403020100, 64'h0f0e0d0c0b0a0908);
    send_word('0, 4'd0, 1'b1);
    send_word('1, sh24_pkg::FULL_BYTES, 1'b1);
    send_word({$urandom, $urandom}, 4'd15, 1'b1);
    send_word('1, 4'd7, 1'b1);
    // Short inner word still absorbs all eight bytes
    send_word('1, 4'd3, 1'b0);
    send_word('1, 4'd1, 1'b1);
    send_word('0, sh24_pkg::FULL_BYTES, 1'b0);
    send_word('0, sh24_pkg::FULL_BYTES, 1'b1);

    // Rekey between words of one message: the old key must finish it
    send_word({$urandom, $urandom}, sh24_pkg::FULL_BYTES, 1'b0);
    send_word({$urandom, $urandom}, sh24_pkg::FULL_BYTES, 1'b0);
    set_keys('1, '1);
    send_word({$urandom, $urandom}, 4'd4, 1'b1);
    send_word('1, 4'd0, 1'b1);
    send_word('1, 4'd9, 1'b1);

    // Random phases, each under its own key; one phase runs with no idling,
    // and one pauses mid-way until every hash is out
    for (int p = 0; p < 6; p++) begin
      case (p)
        1:       set_keys('0, '0);
        2:       set_keys('1, '1);
        default: set_keys({$urandom, $urandom}, {$urandom, $urandom});
      endcase
      quiet <= (p == 4);
      target = words_sent + 266;
      while (words_sent < target) begin
        if (p == 3 && !paused && words_sent > target - 133) begin
          hold_until_drained();
          paused = 1'b1;
        end
        send_random_message();
      end
    end

    // Drain and let the pipeline run dry before the verdict
    hold_until_drained();
    repeat (LATENCY_PAD) @(negedge clk);

    $display("Hashed %0d messages (%0d words) under %0d key settings; %0d hashes compared.",
             msgs_sent, words_sent, key_settings, hashes_seen);
    $display("Tails of 0 to 15 bytes, stray inner counts, length wrap and a mid-message rekey.");
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/sh24_pkg.sv
design/sh24_absorb.sv
design/sh24_final.sv
design/siphash_2_4_stream_top.sv
design/sh24_checker.sv
dv/hash_checker.sv
dv/siphash_2_4_stream_top_test.sv
